// ----- design/nuvf_pkg.sv -----
// Shared types and constants of the next unmarked value finder.
`default_nettype none
package nuvf_pkg;

  localparam int WORD_W = 32;
  localparam int BIT_W  = 5;
  localparam int VAL_W  = 11;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [BIT_W-1:0]  bit_t;
  typedef logic [VAL_W-1:0]  value_t;

  localparam logic OP_MARK  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam value_t LIMIT_RST = 11'd1024;

  typedef struct packed {
    logic accept;
    logic clr_step;
    logic mark_rd;
    logic mark_wr;
    logic q_rd;
    logic q_next;
    logic out_load;
  } nuvf_cmd_t;

  typedef struct packed {
    logic op_query;
    logic mark_ok;
    logic word_last;
    logic miss;
    logic hit;
    logic at_lim;
    logic out_free;
  } nuvf_status_t;

endpackage
`default_nettype wire

// ----- design/nuvf_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none
module nuvf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                                       clk_i,
  input  wire logic                                       we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                           wdata_i,
  input  wire logic                                       re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ----- design/nuvf_ctrl.sv -----
// Controller state machine for clearing, marking and scanning the bitmap.
`default_nettype none
module nuvf_ctrl (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  input  wire nuvf_pkg::nuvf_status_t status_i,
  output nuvf_pkg::nuvf_cmd_t         cmd_o,
  output logic                        in_stall_o
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_MRD   = 3'd2;
  localparam logic [2:0] S_MWR   = 3'd3;
  localparam logic [2:0] S_QRD   = 3'd4;
  localparam logic [2:0] S_QCHK  = 3'd5;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (status_i.word_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (status_i.op_query) begin
            state_d = S_QRD;
          end else if (status_i.mark_ok) begin
            state_d = S_MRD;
          end
        end
      end
      S_MRD: begin
        cmd_o.mark_rd = 1'b1;
        state_d       = S_MWR;
      end
      S_MWR: begin
        cmd_o.mark_wr = 1'b1;
        state_d       = S_IDLE;
      end
      S_QRD: begin
        if (status_i.miss) begin
          if (status_i.out_free) begin
            cmd_o.out_load = 1'b1;
            state_d        = S_IDLE;
          end
        end else begin
          cmd_o.q_rd = 1'b1;
          state_d    = S_QCHK;
        end
      end
      S_QCHK: begin
        if (status_i.hit || status_i.at_lim) begin
          if (status_i.out_free) begin
            cmd_o.out_load = 1'b1;
            state_d        = S_IDLE;
          end
        end else begin
          cmd_o.q_next = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule
`default_nettype wire

// ----- design/nuvf_dp.sv -----
// Datapath with the bitmap memory, scan logic, limit register and output register.
`default_nettype none
module nuvf_dp #(
  parameter int VALUE_SPACE = 1024
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire nuvf_pkg::nuvf_cmd_t           cmd_i,
  output nuvf_pkg::nuvf_status_t             status_o,
  input  wire logic                          opcode_i,
  input  wire logic [nuvf_pkg::VAL_W-1:0]    item_value_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [nuvf_pkg::VAL_W-1:0]    cfg_wdata_i,
  input  wire logic                          out_stall_i,
  output logic                               out_valid_o,
  output logic                               found_o,
  output logic      [nuvf_pkg::VAL_W-1:0]    answer_value_o
);

  localparam int NWORDS = (VALUE_SPACE + nuvf_pkg::WORD_W - 1) / nuvf_pkg::WORD_W;
  localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int VSB    = $clog2(VALUE_SPACE + 1);
  localparam int CW     = (VSB > nuvf_pkg::VAL_W) ? VSB : nuvf_pkg::VAL_W;

  typedef logic [CW-1:0] val_t;
  typedef logic [AW-1:0] waddr_t;

  val_t                 vs_c, item_ext, start_c, idx_c, cfg_lim_c, lim_c, lim_m1_c, cand_c;
  logic                 mark_ok_c, res_found_c;
  nuvf_pkg::value_t     upper_limit_q;
  waddr_t               word_q, lim_word_q, rd_addr_c;
  nuvf_pkg::bit_t       bit_q, pos_c;
  logic                 first_q, miss_q;
  val_t                 lim_q;
  nuvf_pkg::word_t      rdata_c, mask_lo_c, free_c, wdata_c;
  logic                 we_c, re_c;
  logic                 out_valid_q, found_q;
  nuvf_pkg::value_t     answer_q;

  assign vs_c      = val_t'(VALUE_SPACE);
  assign item_ext  = val_t'(item_value_i);
  assign start_c   = (item_ext == '0) ? val_t'(1) : item_ext;
  assign idx_c     = start_c - val_t'(1);
  assign mark_ok_c = (item_ext != '0) && (item_ext <= vs_c);
  assign cfg_lim_c = val_t'(upper_limit_q);
  assign lim_c     = (cfg_lim_c > vs_c) ? vs_c : cfg_lim_c;
  assign lim_m1_c  = lim_c - val_t'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upper_limit_q <= nuvf_pkg::LIMIT_RST;
    end else if (cfg_we_i) begin
      upper_limit_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q <= '0;
    end else if (cmd_i.accept) begin
      word_q <= idx_c[AW+nuvf_pkg::BIT_W-1:nuvf_pkg::BIT_W];
    end else if (cmd_i.clr_step || cmd_i.q_next) begin
      word_q <= word_q + waddr_t'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      bit_q      <= idx_c[nuvf_pkg::BIT_W-1:0];
      first_q    <= 1'b1;
      lim_q      <= lim_c;
      lim_word_q <= lim_m1_c[AW+nuvf_pkg::BIT_W-1:nuvf_pkg::BIT_W];
      miss_q     <= (start_c > lim_c);
    end else if (cmd_i.q_next) begin
      first_q    <= 1'b0;
    end
  end

  assign re_c      = cmd_i.mark_rd || cmd_i.q_rd || cmd_i.q_next;
  assign rd_addr_c = cmd_i.q_next ? (word_q + waddr_t'(1)) : word_q;
  assign we_c      = cmd_i.clr_step || cmd_i.mark_wr;
  assign wdata_c   = cmd_i.mark_wr ? (rdata_c | (nuvf_pkg::word_t'(1) << bit_q)) : '0;

  nuvf_ram #(
    .WIDTH (nuvf_pkg::WORD_W),
    .DEPTH (NWORDS)
  ) u_bitmap (
    .clk_i   (clk_i),
    .we_i    (we_c),
    .waddr_i (word_q),
    .wdata_i (wdata_c),
    .re_i    (re_c),
    .raddr_i (rd_addr_c),
    .rdata_o (rdata_c)
  );

  assign mask_lo_c = (nuvf_pkg::word_t'(1) << bit_q) - nuvf_pkg::word_t'(1);
  assign free_c    = ~(rdata_c | (first_q ? mask_lo_c : '0));

  always_comb begin
    pos_c = '0;
    for (int i = nuvf_pkg::WORD_W - 1; i >= 0; i--) begin
      if (free_c[i]) begin
        pos_c = nuvf_pkg::bit_t'(i);
      end
    end
  end

  assign cand_c      = val_t'({word_q, pos_c}) + val_t'(1);
  assign res_found_c = !miss_q && (|free_c) && (cand_c <= lim_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      found_q  <= res_found_c;
      answer_q <= res_found_c ? cand_c[nuvf_pkg::VAL_W-1:0] : '0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign found_o        = found_q;
  assign answer_value_o = answer_q;

  assign status_o.op_query  = (opcode_i == nuvf_pkg::OP_QUERY);
  assign status_o.mark_ok   = mark_ok_c;
  assign status_o.word_last = (word_q == waddr_t'(NWORDS - 1));
  assign status_o.miss      = miss_q;
  assign status_o.hit       = |free_c;
  assign status_o.at_lim    = (word_q == lim_word_q);
  assign status_o.out_free  = !out_valid_q || !out_stall_i;

endmodule
`default_nettype wire

// ----- design/next_unmarked_value_finder.sv -----
// Top level of the next unmarked value finder.
// The block keeps one mark bit per value 1..VALUE_SPACE in a memory of 32-bit words.
// After reset a clearing pass writes every word once, while in_stall_o stays high;
// the limit register can be written during that time. A mark transaction steps
// through accept, word read and word write; a mark outside 1..VALUE_SPACE is only
// accepted. A query transaction steps through accept and a first word read, then
// checks each bitmap word scanned, from the word of the start value up to the first
// word with a free bit or the word of the limit; a query whose start lies above the
// limit loads its result without a word read. The scan rate is set by the one
// read port of the bitmap memory. Results wait in an output register, so a waiting
// result holds the block only when the next query finishes before it is taken.
`default_nettype none
module next_unmarked_value_finder #(
  parameter int VALUE_SPACE = 1024
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          opcode_i,
  input  wire logic [nuvf_pkg::VAL_W-1:0]    item_value_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [nuvf_pkg::VAL_W-1:0]    cfg_wdata_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               found_o,
  output logic      [nuvf_pkg::VAL_W-1:0]    answer_value_o
);

  nuvf_pkg::nuvf_cmd_t    cmd;
  nuvf_pkg::nuvf_status_t status;

  nuvf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .status_i   (status),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  nuvf_dp #(
    .VALUE_SPACE (VALUE_SPACE)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .opcode_i       (opcode_i),
    .item_value_i   (item_value_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .found_o        (found_o),
    .answer_value_o (answer_value_o)
  );

`ifndef SYNTH
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_o |-> (answer_value_o != '0) &&
                               (32'(answer_value_o) <= VALUE_SPACE))
    else $error("Found result is outside the value space.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> (answer_value_o == '0))
    else $error("Not-found result carries a nonzero value.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("Result appeared without a query in progress.");
`endif

endmodule
`default_nettype wire

// ----- dv/tb_next_unmarked_value_finder.sv -----
// Self-checking testbench for the next unmarked value finder: directed table, then random phases.
`timescale 1ns / 1ps
module tb_next_unmarked_value_finder;

  localparam int VS          = 1024;
  localparam int SETTLE_CYC  = 64;
  localparam int HOLD_CYC    = 400;
  localparam int HOLD_AT     = 300;
  localparam int WDOG_LIMIT  = 4000;
  localparam int N_PHASES    = 11;
  localparam int PHASE_ITEMS = 115;
  localparam int N_DIR       = 28;

  typedef struct packed {
    logic             found;
    nuvf_pkg::value_t answer;
  } answer_t;

  typedef struct packed {
    logic             op;
    nuvf_pkg::value_t val;
    logic             typed;
    logic             found;
    nuvf_pkg::value_t answer;
  } dir_row_t;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_stall_o;
  logic             opcode_i;
  nuvf_pkg::value_t item_value_i;
  logic             cfg_we_i;
  nuvf_pkg::value_t cfg_wdata_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic             found_o;
  nuvf_pkg::value_t answer_value_o;

  bit               marked [1:VS];
  nuvf_pkg::value_t limit_reg;
  answer_t          pending_q [$];
  dir_row_t         dir_tab [N_DIR];

  int  fails;
  int  results_seen;
  int  n_items;
  int  n_marks;
  int  n_queries;
  int  n_notfound;
  int  n_limits;
  int  idle_cnt;
  bit  calm;
  bit  hold_done;

  next_unmarked_value_finder #(
    .VALUE_SPACE(VS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .opcode_i      (opcode_i),
    .item_value_i  (item_value_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .found_o       (found_o),
    .answer_value_o(answer_value_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic answer_t next_free(input nuvf_pkg::value_t start);
    answer_t res;
    int lim;
    int cur;
    lim = (int'(limit_reg) > VS) ? VS : int'(limit_reg);
    cur = (start == '0) ? 1 : int'(start);
    while (cur <= VS && marked[cur]) cur++;
    if (cur <= lim) begin
      res.found  = 1'b1;
      res.answer = nuvf_pkg::value_t'(cur);
    end else begin
      res.found  = 1'b0;
      res.answer = '0;
    end
    return res;
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int pick_gap();
    if (calm || $urandom_range(0, 99) < 55) return 0;
    return pick_len();
  endfunction

  task automatic send_item(input logic op, input nuvf_pkg::value_t v, input logic typed,
                           input logic t_found, input nuvf_pkg::value_t t_answer);
    int gap;
    answer_t exp_res;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   = 1'b1;
    opcode_i     = op;
    item_value_i = v;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    n_items++;
    if (op == nuvf_pkg::OP_QUERY) begin
      exp_res = next_free(v);
      if (typed) begin
        exp_res.found  = t_found;
        exp_res.answer = t_answer;
      end
      if (!exp_res.found) n_notfound++;
      pending_q.push_back(exp_res);
      n_queries++;
    end else begin
      if (v >= 1 && int'(v) <= VS) marked[int'(v)] = 1'b1;
      n_marks++;
    end
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i = 1'b0;
    while (pending_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYC) @(negedge clk_i);
  endtask

  task automatic write_limit(input nuvf_pkg::value_t v);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = v;
    @(negedge clk_i);
    cfg_we_i  = 1'b0;
    limit_reg = v;
    n_limits++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (pending_q.size() == 0) begin
        $error("unexpected result: found %0b answer_value %0d", found_o, answer_value_o);
        fails++;
      end else begin
        if (found_o !== pending_q[0].found) begin
          $error("found mismatch: expected %0b, actual %0b", pending_q[0].found, found_o);
          fails++;
        end
        if (answer_value_o !== pending_q[0].answer) begin
          $error("answer_value mismatch: expected %0d, actual %0d",
                 pending_q[0].answer, answer_value_o);
          fails++;
        end
        void'(pending_q.pop_front());
      end
    end
  end

  initial begin
    int busy;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!hold_done && results_seen >= HOLD_AT) begin
        hold_done   = 1'b1;
        out_stall_i = 1'b1;
        repeat (HOLD_CYC) @(negedge clk_i);
        out_stall_i = 1'b0;
      end else if (!calm && $urandom_range(0, 99) < 25) begin
        busy        = pick_len();
        out_stall_i = 1'b1;
        repeat (busy) @(negedge clk_i);
        out_stall_i = 1'b0;
      end
    end
  end

  initial begin
    idle_cnt = 0;
    while (idle_cnt < WDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cnt = 0;
      else idle_cnt++;
    end
    $display("next_unmarked_value_finder verification failed");
    $finish;
  end

  initial begin
    int               hot_base;
    int               r;
    logic             op;
    nuvf_pkg::value_t v;
    nuvf_pkg::value_t lim;
    in_valid_i   = 1'b0;
    opcode_i     = nuvf_pkg::OP_MARK;
    item_value_i = '0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    rst_ni       = 1'b0;
    limit_reg    = nuvf_pkg::LIMIT_RST;
    calm         = 1'b0;
    hold_done    = 1'b0;
    fails        = 0;
    results_seen = 0;
    n_items      = 0;
    n_marks      = 0;
    n_queries    = 0;
    n_notfound   = 0;
    n_limits     = 0;
    foreach (marked[i]) marked[i] = 1'b0;

    dir_tab = '{
      '{nuvf_pkg::OP_QUERY, 11'd1,    1'b1, 1'b1, 11'd1},
      '{nuvf_pkg::OP_QUERY, 11'd0,    1'b1, 1'b1, 11'd1},
      '{nuvf_pkg::OP_QUERY, 11'd1024, 1'b1, 1'b1, 11'd1024},
      '{nuvf_pkg::OP_QUERY, 11'd1025, 1'b1, 1'b0, 11'd0},
      '{nuvf_pkg::OP_QUERY, 11'd2047, 1'b1, 1'b0, 11'd0},
      '{nuvf_pkg::OP_MARK,  11'd0,    1'b0, 1'b0, 11'd0},
      '{nuvf_pkg::OP_MARK,  11'd2047, 1'b0, 1'b0, 11'd0},
      '{nuvf_pkg::OP_MARK,  11'd1025, 1'b0, 1'b0, 11'd0},
      '{nuvf_pkg::OP_QUERY, 11'd0,    1'b1, 1'b1, 11'd1},
      '{nuvf_pkg::OP_MARK,  11'd1,    1'b0, 1'b0, 11'd0},
      '{nuvf_pkg::OP_QUERY, 11'd0,    1'b0, 1'b0, 11'd0},
      '{nuvf_pkg::OP_MARK,  11'd1024, 1'b0, 1'b0, 11'd0},
      '{nuvf_pkg::OP_QUERY, 11'd1024, 1'b1, 1'b0, 11'd0},
      '{nuvf_pkg::OP_MARK,  11'd1023, 1'b0, 1'b0, 11'd0},
      '{nuvf_pkg::OP_QUERY, 11'd1000, 1'b0, 1'b0, 11'd0},
      '{nuvf_pkg::OP_QUERY, 11'd1023, 1'b1, 1'b0, 11'd0},
      '{nuvf_pkg::OP_MARK,  11'd2,    1'b0, 1'b0, 11'd0},
      '{nuvf_pkg::OP_MARK,  11'd2,    1'b0, 1'b0, 11'd0},
      '{nuvf_pkg::OP_QUERY, 11'd1,    1'b0, 1'b0, 11'd0},
      '{nuvf_pkg::OP_MARK,  11'd32,   1'b0, 1'b0, 11'd0},
      '{nuvf_pkg::OP_MARK,  11'd33,   1'b0, 1'b0, 11'd0},
      '{nuvf_pkg::OP_QUERY, 11'd32,   1'b0, 1'b0, 11'd0},
      '{nuvf_pkg::OP_MARK,  11'd31,   1'b0, 1'b0, 11'd0},
      '{nuvf_pkg::OP_QUERY, 11'd31,   1'b0, 1'b0, 11'd0},
      '{nuvf_pkg::OP_MARK,  11'd1366, 1'b0, 1'b0, 11'd0},
      '{nuvf_pkg::OP_MARK,  11'd681,  1'b0, 1'b0, 11'd0},
      '{nuvf_pkg::OP_QUERY, 11'd681,  1'b0, 1'b0, 11'd0},
      '{nuvf_pkg::OP_QUERY, 11'd512,  1'b0, 1'b0, 11'd0}
    };

    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_tab[i]) begin
      send_item(dir_tab[i].op, dir_tab[i].val, dir_tab[i].typed,
                dir_tab[i].found, dir_tab[i].answer);
    end

    hot_base = 1;
    for (int p = 0; p < N_PHASES; p++) begin
      wait_drained();
      case (p)
        0:       lim = 11'd0;
        1:       lim = 11'd1;
        2:       lim = 11'd2047;
        3:       lim = 11'd33;
        4:       lim = nuvf_pkg::LIMIT_RST;
        6:       lim = 11'd1025;
        8:       lim = 11'd1023;
        10:      lim = nuvf_pkg::LIMIT_RST;
        default: lim = nuvf_pkg::value_t'($urandom_range(2, 1022));
      endcase
      write_limit(lim);
      calm = (p % 5 == 1);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k % 40 == 39 && hot_base < 1000) hot_base += 20;
        if (p == 2 && k == PHASE_ITEMS / 2) wait_drained();
        r = $urandom_range(0, 99);
        if (r < 45) begin
          op = nuvf_pkg::OP_MARK;
          v  = nuvf_pkg::value_t'(hot_base + $urandom_range(0, 63));
        end else if (r < 50) begin
          op = nuvf_pkg::OP_MARK;
          v  = nuvf_pkg::value_t'($urandom_range(0, 2047));
        end else if (r < 85) begin
          op = nuvf_pkg::OP_QUERY;
          v  = nuvf_pkg::value_t'($urandom_range(0, hot_base + 64));
        end else begin
          op = nuvf_pkg::OP_QUERY;
          v  = nuvf_pkg::value_t'($urandom_range(0, 2047));
        end
        send_item(op, v, 1'b0, 1'b0, '0);
      end
    end

    wait_drained();
    $display("Run covered %0d transactions (%0d marks, %0d queries) under %0d limit settings.",
             n_items, n_marks, n_queries, n_limits);
    $display("Checked %0d results, %0d of them not found.", results_seen, n_notfound);
    if (fails == 0) begin
      $display("next_unmarked_value_finder verification clean");
    end else begin
      $display("next_unmarked_value_finder verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/nuvf_pkg.sv
design/nuvf_ram.sv
design/nuvf_ctrl.sv
design/nuvf_dp.sv
design/next_unmarked_value_finder.sv
dv/tb_next_unmarked_value_finder.sv
